>>> hdl/crc32sc_pkg.sv
package crc32sc_pkg;

  localparam logic [31:0] CrcPoly    = 32'hEDB88320;
  localparam logic [31:0] CrcInit    = 32'hFFFFFFFF;
  localparam logic [31:0] CrcXorOut  = 32'hFFFFFFFF;
  localparam int unsigned TailBytes  = 4;
  localparam int unsigned CountWidth = 3;

  // Result of one message, as shown on the output channel.
  typedef struct packed {
    logic [31:0] crc_value;
    logic        match;
    logic        too_short;
  } result_t;

  // Advance a reflected CRC-32 by one byte, least significant bit first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] x;
    x = {24'h000000, crc[7:0] ^ data};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CrcPoly) : (x >> 1);
    end
    return x ^ (crc >> 8);
  endfunction

endpackage

>>> hdl/crc32sc_core.sv
module crc32sc_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   step_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   last_byte_i,
  output crc32sc_pkg::result_t   res_o
);

  logic                                verify_q;
  logic [31:0]                         crc_q, crc_d;
  logic [31:0]                         tail_q, tail_d;
  logic [crc32sc_pkg::CountWidth-1:0]  cnt_q, cnt_d;
  logic                                full;
  logic [31:0]                         crc_out;

  assign full = (cnt_q >= crc32sc_pkg::CountWidth'(crc32sc_pkg::TailBytes));

  always_comb begin
    crc_d  = crc_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (!verify_q) begin
      crc_d = crc32sc_pkg::crc_byte(crc_q, data_byte_i);
    end else begin
      // bytes leaving the window are body bytes
      if (full) begin
        crc_d = crc32sc_pkg::crc_byte(crc_q, tail_q[7:0]);
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
      tail_d = {data_byte_i, tail_q[31:8]};
    end
  end

  assign crc_out = crc_d ^ crc32sc_pkg::CrcXorOut;

  always_comb begin
    res_o.crc_value = crc_out;
    res_o.match     = 1'b0;
    res_o.too_short = 1'b0;
    if (verify_q) begin
      if (cnt_d < crc32sc_pkg::CountWidth'(crc32sc_pkg::TailBytes)) begin
        res_o.too_short = 1'b1;
      end else begin
        res_o.match = (tail_d == crc_out);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verify_q <= 1'b0;
      crc_q    <= crc32sc_pkg::CrcInit;
      tail_q   <= '0;
      cnt_q    <= '0;
    end else if (cfg_we_i) begin
      // mode change abandons any message in progress
      verify_q <= cfg_wdata_i;
      crc_q    <= crc32sc_pkg::CrcInit;
      tail_q   <= '0;
      cnt_q    <= '0;
    end else if (step_i) begin
      if (last_byte_i) begin
        crc_q  <= crc32sc_pkg::CrcInit;
        tail_q <= '0;
        cnt_q  <= '0;
      end else begin
        crc_q  <= crc_d;
        tail_q <= tail_d;
        cnt_q  <= cnt_d;
      end
    end
  end

endmodule

>>> hdl/crc32_stream_check_top.sv
// Streaming CRC-32 check (reflected, polynomial EDB88320, init and final XOR all ones).
// Input channel: one message byte per beat on data_byte_i, last_byte_i marking the
//   final byte, with in_valid_i / in_ready_o.
// Output channel: one beat per message, on its final byte: crc_value_o, match_o and
//   too_short_o, with out_valid_o / out_ready_i.
// Configuration: cfg_we_i writes cfg_wdata_i into the verify mode bit (0 compute,
//   1 verify the trailing four stored checksum bytes, least significant first);
//   every write also clears the message state. Write only while the block is idle.
// Result path: a last byte accepted into the input register passes through the CRC
//   byte step into the result register, which drives out_valid_o; while an earlier
//   result beat is still held there, the last byte waits in the input register.
// Throughput: one byte per cycle while no last byte waits on a held result beat, set by
//   the single byte-wide CRC update between the input register and the state registers.
// Reset: asynchronous, active low; compute mode, CRC all ones, window and count empty,
//   both channels empty.
// Stall: while a result beat waits, body bytes keep flowing; a last byte held in the
//   input register waits for the result register to free, and in_ready_o stays low
//   meanwhile.
module crc32_stream_check_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] crc_value_o,
  output logic        match_o,
  output logic        too_short_o
);

  logic                  s1_valid_q;
  logic [7:0]            s1_byte_q;
  logic                  s1_last_q;
  logic                  out_free;
  logic                  s1_go;
  logic                  out_valid_q;
  crc32sc_pkg::result_t  res;
  crc32sc_pkg::result_t  out_q;

  // Advance the held byte unless it is a last byte with nowhere to put its result.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;

  crc32sc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (s1_go),
    .data_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .res_o       (res)
  );

  // Input register: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Input register: payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // Result register: load on a stepped last byte, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign crc_value_o = out_q.crc_value;
  assign match_o     = out_q.match;
  assign too_short_o = out_q.too_short;

endmodule

>>> hdl/crc32sc_checker.sv
module crc32sc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] crc_value_o,
  input logic        match_o,
  input logic        too_short_o
);

  // A waiting result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(crc_value_o)
      && $stable(match_o) && $stable(too_short_o))
    else $error("result beat changed while stalled");

  // Input stalls only behind a stalled result.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(match_o && too_short_o))
    else $error("match and too_short both set");

  // A short message has an empty body.
  a_short_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_short_o |-> crc_value_o == 32'h00000000)
    else $error("short message with non-empty body checksum");

endmodule

bind crc32_stream_check_top crc32sc_checker u_crc32sc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .crc_value_o (crc_value_o),
  .match_o     (match_o),
  .too_short_o (too_short_o)
);
